// ===== rtl/core/imim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imim_pkg
// Shared types and constants for the image negative and mean statistics block.
// ----------------------------------------------------------------------------
package imim_pkg;

	localparam int MAX_ROWS_DEF    = 64;
	localparam int MAX_COLUMNS_DEF = 32;

	localparam int PIX_W  = 8;
	localparam int IDX_W  = 6;
	localparam int KIND_W = 2;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int ROW_COUNT_W = 7;
	localparam int COL_COUNT_W = 6;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ROW   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_IMAGE = 2'd3;

	// register select, taken from the word address bit
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 7'd64;
	localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = 6'd32;

	typedef struct packed {
		logic [ROW_COUNT_W-1:0] row_count;
		logic [COL_COUNT_W-1:0] column_count;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] quot;
	} div_res_t;

endpackage

// ===== rtl/core/image_invert_and_mean_stats_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_invert_and_mean_stats_top
// Grey image negative with row, column and image means. Each pixel is emitted
// inverted; row means follow each row, column and image means the last pixel.
//
//   channel  dir  fields
//   s_*      in   tdata[7:0] pixel
//   m_*      out  tdata[5:0] index, tdata[13:6] value; tuser[1:0] kind; tlast
//   apb      in   0x0 row_count[6:0], 0x4 column_count[5:0]
//
// A pixel is transferred, then its column sum gets a read-modify-write before
// the next pixel is taken. A row end runs the shared 8-step divider (no steps
// when the mean saturates); the image end runs it per column and for the image
// mean. Column store valid bits clear at reset and after each image.
// A stalled m side holds the sequencer; no input is taken until it drains.
// ----------------------------------------------------------------------------
module image_invert_and_mean_stats_top #(
	parameter int MAX_ROWS    = imim_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = imim_pkg::MAX_COLUMNS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // pixel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,   // index, value, zero pad
	output logic [imim_pkg::KIND_W-1:0]         m_tuser,   // kind
	output logic                                m_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [imim_pkg::ADDR_W-1:0]         paddr,
	input  logic [imim_pkg::DATA_W-1:0]         pwdata,
	output logic [imim_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);

	localparam int PW     = imim_pkg::PIX_W;
	localparam int IW     = imim_pkg::IDX_W;
	localparam int KW     = imim_pkg::KIND_W;
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
	localparam int RP_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CP_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RA_W   = $clog2(MAX_COLUMNS * 255 + 1);
	localparam int CA_W   = $clog2(MAX_ROWS * 255 + 1);
	localparam int IA_W   = $clog2(MAX_ROWS * MAX_COLUMNS * 255 + 1);
	localparam int NUM_W  = IA_W + 1;
	localparam int DEN_W  = $clog2(MAX_ROWS * MAX_COLUMNS + 1);
	localparam int CMP_W  = 9;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_RDIV = 3'd2;
	localparam logic [2:0] ST_CADR = 3'd3;
	localparam logic [2:0] ST_CST  = 3'd4;
	localparam logic [2:0] ST_CDIV = 3'd5;
	localparam logic [2:0] ST_IST  = 3'd6;
	localparam logic [2:0] ST_IDIV = 3'd7;

	imim_pkg::cfg_t     cfg;
	imim_pkg::div_res_t div_res;

	logic [ROWS_W-1:0] eff_rows;
	logic [COLS_W-1:0] eff_cols;
	logic [DEN_W-1:0]  prod_q;

	logic [2:0]        state_q;
	logic [2:0]        state_nxt;
	logic [RA_W-1:0]   row_accum_q;
	logic [IA_W-1:0]   image_accum_q;
	logic [RP_W-1:0]   row_pos_q;
	logic [CP_W-1:0]   col_pos_q;
	logic [RP_W-1:0]   row_idx_q;
	logic [CP_W-1:0]   col_q;
	logic [CP_W-1:0]   col_idx_q;
	logic [PW-1:0]     inv_q;
	logic              rowend_q;
	logic              imgend_q;

	logic              accept;
	logic              slot_free;
	logic [PW-1:0]     inv;
	logic              row_end;
	logic              img_end;
	logic              col_done;

	logic              out_valid_q;
	logic [KW-1:0]     out_kind_q;
	logic [IW-1:0]     out_index_q;
	logic [PW-1:0]     out_value_q;
	logic              out_last_q;
	logic              out_load;
	logic [KW-1:0]     out_kind;
	logic [IW-1:0]     out_index;
	logic [PW-1:0]     out_value;
	logic              out_last;

	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;

	logic [CP_W-1:0]   mem_rd_addr;
	logic [CA_W-1:0]   mem_rd_data;
	logic              mem_wr_en;
	logic              mem_clr;

	imim_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	always_comb begin
		if (cfg.row_count == '0) begin
			eff_rows = ROWS_W'(1);
		end else if (CMP_W'(cfg.row_count) > CMP_W'(MAX_ROWS)) begin
			eff_rows = ROWS_W'(MAX_ROWS);
		end else begin
			eff_rows = ROWS_W'(cfg.row_count);
		end
		if (cfg.column_count == '0) begin
			eff_cols = COLS_W'(1);
		end else if (CMP_W'(cfg.column_count) > CMP_W'(MAX_COLUMNS)) begin
			eff_cols = COLS_W'(MAX_COLUMNS);
		end else begin
			eff_cols = COLS_W'(cfg.column_count);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= DEN_W'(eff_rows) * DEN_W'(eff_cols);
	end

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign inv       = imim_pkg::PIX_MAX - s_tdata[PW-1:0];
	assign row_end   = (CMP_W'(col_pos_q) + CMP_W'(1)) >= CMP_W'(eff_cols);
	assign img_end   = row_end && ((CMP_W'(row_pos_q) + CMP_W'(1)) >= CMP_W'(eff_rows));
	assign col_done  = (CMP_W'(col_idx_q) + CMP_W'(1)) >= CMP_W'(eff_cols);

	assign mem_rd_addr = (state_q == ST_IDLE) ? col_pos_q : col_idx_q;
	assign mem_wr_en   = (state_q == ST_UPD);

	imim_colmem #(
		.DEPTH (MAX_COLUMNS),
		.AW    (CP_W),
		.W     (CA_W)
	) u_colmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (mem_clr),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (col_q),
		.wr_data (mem_rd_data + CA_W'(inv_q))
	);

	always_comb begin
		div_start = 1'b0;
		div_num   = NUM_W'(row_accum_q);
		div_den   = DEN_W'(eff_cols);
		case (state_q)
			ST_UPD: begin
				div_start = rowend_q;
			end
			ST_CST: begin
				div_start = 1'b1;
				div_num   = NUM_W'(mem_rd_data);
				div_den   = DEN_W'(eff_rows);
			end
			ST_IST: begin
				div_start = 1'b1;
				div_num   = NUM_W'(image_accum_q);
				div_den   = prod_q;
			end
			default: begin
			end
		endcase
	end

	imim_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	// sequencer
	always_comb begin
		state_nxt = state_q;
		out_load  = 1'b0;
		out_kind  = imim_pkg::KIND_PIXEL;
		out_index = '0;
		out_value = inv;
		out_last  = 1'b0;
		mem_clr   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					out_load  = 1'b1;
					out_last  = !row_end;
					state_nxt = ST_UPD;
				end
			end
			ST_UPD: begin
				state_nxt = rowend_q ? ST_RDIV : ST_IDLE;
			end
			ST_RDIV: begin
				if (div_res.done && slot_free) begin
					out_load  = 1'b1;
					out_kind  = imim_pkg::KIND_ROW;
					out_index = IW'(row_idx_q);
					out_value = div_res.quot;
					out_last  = !imgend_q;
					state_nxt = imgend_q ? ST_CADR : ST_IDLE;
				end
			end
			ST_CADR: begin
				state_nxt = ST_CST;
			end
			ST_CST: begin
				state_nxt = ST_CDIV;
			end
			ST_CDIV: begin
				if (div_res.done && slot_free) begin
					out_load  = 1'b1;
					out_kind  = imim_pkg::KIND_COL;
					out_index = IW'(col_idx_q);
					out_value = div_res.quot;
					state_nxt = col_done ? ST_IST : ST_CADR;
				end
			end
			ST_IST: begin
				state_nxt = ST_IDIV;
			end
			ST_IDIV: begin
				if (div_res.done && slot_free) begin
					out_load  = 1'b1;
					out_kind  = imim_pkg::KIND_IMAGE;
					out_value = div_res.quot;
					out_last  = 1'b1;
					mem_clr   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			row_accum_q   <= '0;
			image_accum_q <= '0;
			row_pos_q     <= '0;
			col_pos_q     <= '0;
			col_idx_q     <= '0;
			rowend_q      <= 1'b0;
			imgend_q      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				row_accum_q   <= row_accum_q + RA_W'(inv);
				image_accum_q <= image_accum_q + IA_W'(inv);
				rowend_q      <= row_end;
				imgend_q      <= img_end;
				if (row_end) begin
					col_pos_q <= '0;
					row_pos_q <= img_end ? '0 : row_pos_q + 1'b1;
				end else begin
					col_pos_q <= col_pos_q + 1'b1;
				end
			end
			if (state_q == ST_UPD && rowend_q) begin
				row_accum_q <= '0;
			end
			if (state_q == ST_RDIV && out_load) begin
				col_idx_q <= '0;
			end
			if (state_q == ST_CDIV && out_load && !col_done) begin
				col_idx_q <= col_idx_q + 1'b1;
			end
			if (mem_clr) begin
				image_accum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inv_q     <= inv;
			col_q     <= col_pos_q;
			row_idx_q <= row_pos_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q  <= out_kind;
			out_index_q <= out_index;
			out_value_q <= out_value;
			out_last_q  <= out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_value_q, out_index_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/core/imim_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imim_cfg
// Configuration registers behind the register port: row and column counts.
// ----------------------------------------------------------------------------
module imim_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [imim_pkg::ADDR_W-1:0]         paddr,
	input  logic [imim_pkg::DATA_W-1:0]         pwdata,
	output logic [imim_pkg::DATA_W-1:0]         prdata,
	output imim_pkg::cfg_t                      cfg
);

	imim_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count    <= imim_pkg::ROW_COUNT_RST;
			cfg_q.column_count <= imim_pkg::COL_COUNT_RST;
		end else if (wr_en) begin
			case (paddr[2])
				imim_pkg::REG_ROW_COUNT: begin
					cfg_q.row_count <= pwdata[imim_pkg::ROW_COUNT_W-1:0];
				end
				imim_pkg::REG_COL_COUNT: begin
					cfg_q.column_count <= pwdata[imim_pkg::COL_COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			imim_pkg::REG_ROW_COUNT: begin
				prdata = imim_pkg::DATA_W'(cfg_q.row_count);
			end
			imim_pkg::REG_COL_COUNT: begin
				prdata = imim_pkg::DATA_W'(cfg_q.column_count);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/imim_colmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imim_colmem
// Column sum store: one write port, one registered read port, per-entry valid
// bits so that unwritten entries read as zero after reset or a clear.
// ----------------------------------------------------------------------------
module imim_colmem #(
	parameter int DEPTH  = imim_pkg::MAX_COLUMNS_DEF,
	parameter int AW     = 5,
	parameter int W      = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data
);

	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [W-1:0]     rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/imim_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imim_div
// Shared restoring divider with an 8-bit quotient saturated at 255: one
// quotient bit per cycle after an up-front overflow check.
// ----------------------------------------------------------------------------
module imim_div #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output imim_pkg::div_res_t   res
);

	localparam int QW    = imim_pkg::PIX_W;
	localparam int SHW   = NUM_W - QW;
	localparam int CMP_W = (SHW > DEN_W) ? SHW : DEN_W;
	localparam int CW    = $clog2(QW);

	logic [SHW-1:0]   num_hi;
	logic             sat;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    low_q;
	logic [QW-1:0]    quot_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign num_hi = num[NUM_W-1:QW];
	assign sat    = CMP_W'(num_hi) >= CMP_W'(den);
	assign trial  = {rem_q, low_q[QW-1]};
	assign diff   = trial - {1'b0, den_q};
	assign ge     = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat;
			done_q <= sat;
			cnt_q  <= CW'(QW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= DEN_W'(num_hi);
			low_q  <= num[QW-1:0];
			quot_q <= sat ? imim_pkg::PIX_MAX : '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q  <= {low_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule
